FILE: design/hrt_pkg.sv
// Shared types and codes for the bucketed hash refcount table.
// No dependencies; every other file of the block but hrt_divider imports this package.
package hrt_pkg;

	localparam int DEF_NUM_BUCKETS = 1024;
	localparam int DEF_WAYS        = 8;
	localparam int BUCKET_COUNT_W  = 11;
	localparam int REFS_W          = 32;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_DATA_W      = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INITIAL_REFS = 2'd1;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_DEREF  = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_FULL   = 2'd1;
	localparam logic [1:0] ST_ABSENT = 2'd2;
	localparam logic [1:0] ST_SAT    = 2'd3;

	typedef struct packed {
		logic        cmd;
		logic [63:0] key_word0;
		logic [63:0] key_word1;
		logic [63:0] key_word2;
		logic [63:0] key_word3;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        found;
		logic [9:0]  bucket_index;
		logic [2:0]  position;
		logic [31:0] ref_count;
		logic        still_referenced;
		logic [3:0]  collisions;
	} out_word_t;

	// Strobes from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic fill_rd;
		logic fill_wr;
		logic fill_clr;
		logic ent_rd;
		logic key_we;
		logic ref_we;
		logic src_new;
		logic cnt_inc;
		logic cnt_dec;
		logic cnt_init;
		logic res_load;
	} hrt_cmd_t;

	// Result fields that the controller decides.
	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [2:0] position;
		logic       still;
		logic [3:0] collisions;
		logic       use_cnt;
	} hrt_res_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mod_done;
		logic key_match;
		logic ref_max;
		logic cnt_zero;
		logic cmd;
	} hrt_stat_t;

endpackage

FILE: design/bucketed_hash_refcount_table_core.sv
// Top level of the bucketed hash refcount table: controller plus datapath.
// Uses hrt_pkg, hrt_ctrl, hrt_datapath (which holds hrt_divider).
//
//   Channel  Direction  Handshake               Payload
//   in       input      in_valid / in_ready     in_word_t: cmd, key_word0..3
//   out      output     out_valid / out_ready   out_word_t: status .. collisions
//   cfg      input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One word is processed at a time. A word is accepted, runs through the bit-serial
// modulo unit, reads the bucket fill, compares the entries of the bucket in order,
// shifts the entries it moves one by one, and writes back and loads the result.
// After reset the fill memory is cleared, one bucket a cycle; while it is cleared no
// input word is taken, but configuration is taken throughout.
// The result register decouples the output: a new word is accepted while the
// previous result still waits, and only the final load stalls on out_ready.
module bucketed_hash_refcount_table_core import hrt_pkg::*; #(
	parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
	parameter int WAYS        = DEF_WAYS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_word_t              in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_word_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int SW    = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int FW    = $clog2(WAYS + 1);

	hrt_cmd_t         cmd;
	hrt_res_t         res;
	hrt_stat_t        stat;
	logic [SW-1:0]    rd_slot;
	logic [SW-1:0]    wr_slot;
	logic [BKT_W-1:0] clr_addr;
	logic [FW-1:0]    fill_wr_val;
	logic [FW-1:0]    fill_rd;

	// Configuration registers are always writable.
	assign cfg_ready = 1'b1;

	hrt_ctrl #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.WAYS        (WAYS),
		.BKT_W       (BKT_W),
		.SW          (SW),
		.FW          (FW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.stat        (stat),
		.fill_rd     (fill_rd),
		.cmd         (cmd),
		.res         (res),
		.rd_slot     (rd_slot),
		.wr_slot     (wr_slot),
		.clr_addr    (clr_addr),
		.fill_wr_val (fill_wr_val)
	);

	hrt_datapath #(
		.NUM_BUCKETS (NUM_BUCKETS),
		.WAYS        (WAYS),
		.BKT_W       (BKT_W),
		.SW          (SW),
		.FW          (FW)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_valid & cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.res         (res),
		.rd_slot     (rd_slot),
		.wr_slot     (wr_slot),
		.clr_addr    (clr_addr),
		.fill_wr_val (fill_wr_val),
		.fill_rd     (fill_rd),
		.stat        (stat),
		.out_data    (out_data)
	);

endmodule

FILE: design/hrt_divider.sv
// Iterative 32-bit modulo unit, one remainder bit per cycle.
// Depends on nothing but its ports.
module hrt_divider #(
	parameter int DW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] rem
);

	logic [31:0]   dvd_q;
	logic [DW-1:0] dsr_q;
	logic [DW-1:0] rem_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;

	assign trial = {rem_q, dvd_q[31]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= diff[DW-1:0];
			end else begin
				rem_q <= trial[DW-1:0];
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: design/hrt_datapath.sv
// Datapath of the hash refcount table: config registers, key, modulo unit,
// entry and fill memories, count arithmetic and result register. Uses hrt_pkg, hrt_divider.
module hrt_datapath import hrt_pkg::*; #(
	parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
	parameter int WAYS        = DEF_WAYS,
	parameter int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
	parameter int SW          = (WAYS > 1) ? $clog2(WAYS) : 1,
	parameter int FW          = $clog2(WAYS + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  in_word_t              in_data,
	input  hrt_cmd_t              cmd,
	input  hrt_res_t              res,
	input  logic [SW-1:0]         rd_slot,
	input  logic [SW-1:0]         wr_slot,
	input  logic [BKT_W-1:0]      clr_addr,
	input  logic [FW-1:0]         fill_wr_val,
	output logic [FW-1:0]         fill_rd,
	output hrt_stat_t             stat,
	output out_word_t             out_data
);

	localparam int DW      = $clog2(NUM_BUCKETS + 1);
	localparam int ENTRIES = NUM_BUCKETS * WAYS;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [BUCKET_COUNT_W-1:0] bucket_count_q;
	logic [REFS_W-1:0]         init_refs_q;
	in_word_t                  in_q;
	logic [BKT_W-1:0]          bucket_q;
	logic [AW-1:0]             base_q;
	logic [255:0]              key_rd_q;
	logic [REFS_W-1:0]         ref_rd_q;
	logic [REFS_W-1:0]         cnt_q;
	logic [FW-1:0]             fill_rd_q;
	out_word_t                 out_q;

	logic [255:0]      key_mem [ENTRIES];
	logic [REFS_W-1:0] ref_mem [ENTRIES];
	logic [FW-1:0]     fill_mem [NUM_BUCKETS];

	logic [31:0]      bc_ext;
	logic [31:0]      div_eff;
	logic             mod_done;
	logic [DW-1:0]    rem;
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    wr_addr;
	logic [BKT_W-1:0] fill_addr;
	logic [255:0]     key_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_W'(1024);
			init_refs_q    <= REFS_W'(1);
		end else if (cfg_we) begin
			if (cfg_index == REG_BUCKET_COUNT) begin
				bucket_count_q <= cfg_data[BUCKET_COUNT_W-1:0];
			end else if (cfg_index == REG_INITIAL_REFS) begin
				init_refs_q <= cfg_data[REFS_W-1:0];
			end
		end
	end

	// A zero count means one bucket; counts above the table size are clamped.
	assign bc_ext  = 32'(bucket_count_q);
	assign div_eff = (bc_ext == 32'd0) ? 32'd1 :
		(bc_ext > 32'(NUM_BUCKETS)) ? 32'(NUM_BUCKETS) : bc_ext;

	hrt_divider #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.load),
		.dividend (in_data.key_word0[31:0]),
		.divisor  (DW'(div_eff)),
		.done     (mod_done),
		.rem      (rem)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (mod_done) begin
			bucket_q <= BKT_W'(rem);
			base_q   <= AW'(32'(rem) * 32'(WAYS));
		end
	end

	assign key_in    = {in_q.key_word0, in_q.key_word1, in_q.key_word2, in_q.key_word3};
	assign rd_addr   = base_q + AW'(rd_slot);
	assign wr_addr   = base_q + AW'(wr_slot);
	assign fill_addr = cmd.fill_clr ? clr_addr : bucket_q;

	always_ff @(posedge clk) begin
		if (cmd.ent_rd) begin
			key_rd_q <= key_mem[rd_addr];
			ref_rd_q <= ref_mem[rd_addr];
		end
		if (cmd.key_we) begin
			key_mem[wr_addr] <= cmd.src_new ? key_in : key_rd_q;
		end
		if (cmd.ref_we) begin
			ref_mem[wr_addr] <= cmd.src_new ? cnt_q : ref_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_rd) begin
			fill_rd_q <= fill_mem[bucket_q];
		end
		if (cmd.fill_wr) begin
			fill_mem[fill_addr] <= fill_wr_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cnt_inc) begin
			cnt_q <= (&ref_rd_q) ? ref_rd_q : ref_rd_q + REFS_W'(1);
		end else if (cmd.cnt_dec) begin
			cnt_q <= (ref_rd_q == '0) ? '0 : ref_rd_q - REFS_W'(1);
		end else if (cmd.cnt_init) begin
			cnt_q <= (init_refs_q == '0) ? REFS_W'(1) : init_refs_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_q.status           <= res.status;
			out_q.found            <= res.found;
			out_q.bucket_index     <= 10'(bucket_q);
			out_q.position         <= res.position;
			out_q.ref_count        <= res.use_cnt ? cnt_q : '0;
			out_q.still_referenced <= res.still;
			out_q.collisions       <= res.collisions;
		end
	end

	assign stat.mod_done  = mod_done;
	assign stat.key_match = (key_rd_q == key_in);
	assign stat.ref_max   = &ref_rd_q;
	assign stat.cnt_zero  = (cnt_q == '0);
	assign stat.cmd       = in_q.cmd;
	assign fill_rd        = fill_rd_q;
	assign out_data       = out_q;

endmodule

FILE: design/hrt_ctrl.sv
// Controller state machine of the hash refcount table: clearing pass, scan,
// shifts and result hand-off. Uses hrt_pkg; drives hrt_datapath.
module hrt_ctrl import hrt_pkg::*; #(
	parameter int NUM_BUCKETS = DEF_NUM_BUCKETS,
	parameter int WAYS        = DEF_WAYS,
	parameter int BKT_W       = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
	parameter int SW          = (WAYS > 1) ? $clog2(WAYS) : 1,
	parameter int FW          = $clog2(WAYS + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  hrt_stat_t        stat,
	input  logic [FW-1:0]    fill_rd,
	output hrt_cmd_t         cmd,
	output hrt_res_t         res,
	output logic [SW-1:0]    rd_slot,
	output logic [SW-1:0]    wr_slot,
	output logic [BKT_W-1:0] clr_addr,
	output logic [FW-1:0]    fill_wr_val
);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_MOD   = 4'd2;
	localparam logic [3:0] S_FRD   = 4'd3;
	localparam logic [3:0] S_FWAIT = 4'd4;
	localparam logic [3:0] S_SCAN  = 4'd5;
	localparam logic [3:0] S_CMP   = 4'd6;
	localparam logic [3:0] S_UP    = 4'd7;
	localparam logic [3:0] S_UPW   = 4'd8;
	localparam logic [3:0] S_FRONT = 4'd9;
	localparam logic [3:0] S_DEC   = 4'd10;
	localparam logic [3:0] S_DN    = 4'd11;
	localparam logic [3:0] S_DNW   = 4'd12;
	localparam logic [3:0] S_RES   = 4'd13;

	logic [3:0]       state_q, state_d;
	logic [BKT_W-1:0] clr_q;
	logic [FW-1:0]    fill_q, fill_d;
	logic [FW-1:0]    p_q, p_d;
	logic [FW-1:0]    k_q, k_d;
	logic [1:0]       status_q, status_d;
	logic             found_q, found_d;
	logic             still_q, still_d;
	logic             ins_q, ins_d;
	logic             out_valid_q;
	logic [FW:0]      k_next;

	assign k_next = {1'b0, k_q} + (FW+1)'(1);

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		p_d         = p_q;
		k_d         = k_q;
		status_d    = status_q;
		found_d     = found_q;
		still_d     = still_q;
		ins_d       = ins_q;
		cmd         = '0;
		rd_slot     = '0;
		wr_slot     = '0;
		fill_wr_val = '0;
		in_ready    = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.fill_wr  = 1'b1;
				cmd.fill_clr = 1'b1;
				if (clr_q == BKT_W'(NUM_BUCKETS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					status_d = ST_OK;
					found_d  = 1'b0;
					still_d  = 1'b0;
					ins_d    = 1'b0;
					state_d  = S_MOD;
				end
			end
			S_MOD: begin
				if (stat.mod_done) begin
					state_d = S_FRD;
				end
			end
			S_FRD: begin
				cmd.fill_rd = 1'b1;
				state_d     = S_FWAIT;
			end
			S_FWAIT: begin
				fill_d  = (fill_rd > FW'(WAYS)) ? FW'(WAYS) : fill_rd;
				p_d     = '0;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (p_q == fill_q) begin
					// Miss: p_q already holds the fill as the compare count.
					if (stat.cmd == CMD_DEREF) begin
						status_d = ST_ABSENT;
						state_d  = S_RES;
					end else if (fill_q == FW'(WAYS)) begin
						status_d = ST_FULL;
						state_d  = S_RES;
					end else begin
						cmd.cnt_init = 1'b1;
						k_d          = fill_q;
						ins_d        = 1'b1;
						state_d      = S_UP;
					end
				end else begin
					cmd.ent_rd = 1'b1;
					rd_slot    = p_q[SW-1:0];
					state_d    = S_CMP;
				end
			end
			S_CMP: begin
				if (stat.key_match) begin
					found_d = 1'b1;
					if (stat.cmd == CMD_DEREF) begin
						cmd.cnt_dec = 1'b1;
						state_d     = S_DEC;
					end else begin
						cmd.cnt_inc = 1'b1;
						status_d    = stat.ref_max ? ST_SAT : ST_OK;
						k_d         = p_q;
						state_d     = S_UP;
					end
				end else begin
					p_d     = p_q + FW'(1);
					state_d = S_SCAN;
				end
			end
			S_UP: begin
				if (k_q == '0) begin
					state_d = S_FRONT;
				end else begin
					cmd.ent_rd = 1'b1;
					rd_slot    = SW'(k_q - FW'(1));
					state_d    = S_UPW;
				end
			end
			S_UPW: begin
				cmd.key_we = 1'b1;
				cmd.ref_we = 1'b1;
				wr_slot    = k_q[SW-1:0];
				k_d        = k_q - FW'(1);
				state_d    = S_UP;
			end
			S_FRONT: begin
				cmd.key_we  = 1'b1;
				cmd.ref_we  = 1'b1;
				cmd.src_new = 1'b1;
				if (ins_q) begin
					cmd.fill_wr = 1'b1;
					fill_wr_val = fill_q + FW'(1);
				end
				state_d = S_RES;
			end
			S_DEC: begin
				if (stat.cnt_zero) begin
					k_d     = p_q;
					state_d = S_DN;
				end else begin
					cmd.ref_we  = 1'b1;
					cmd.src_new = 1'b1;
					wr_slot     = p_q[SW-1:0];
					still_d     = 1'b1;
					state_d     = S_RES;
				end
			end
			S_DN: begin
				if (k_next >= {1'b0, fill_q}) begin
					cmd.fill_wr = 1'b1;
					fill_wr_val = fill_q - FW'(1);
					state_d     = S_RES;
				end else begin
					cmd.ent_rd = 1'b1;
					rd_slot    = SW'(k_next);
					state_d    = S_DNW;
				end
			end
			S_DNW: begin
				cmd.key_we = 1'b1;
				cmd.ref_we = 1'b1;
				wr_slot    = k_q[SW-1:0];
				k_d        = FW'(k_next);
				state_d    = S_DN;
			end
			S_RES: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			fill_q      <= '0;
			p_q         <= '0;
			k_q         <= '0;
			status_q    <= ST_OK;
			found_q     <= 1'b0;
			still_q     <= 1'b0;
			ins_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			fill_q   <= fill_d;
			p_q      <= p_d;
			k_q      <= k_d;
			status_q <= status_d;
			found_q  <= found_d;
			still_q  <= still_d;
			ins_q    <= ins_d;
			if (state_q == S_CLR) begin
				clr_q <= clr_q + BKT_W'(1);
			end
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.status     = status_q;
	assign res.found      = found_q;
	assign res.position   = (found_q && stat.cmd == CMD_DEREF) ? 3'(p_q) : 3'd0;
	assign res.still      = still_q;
	assign res.collisions = 4'(p_q);
	assign res.use_cnt    = (status_q == ST_OK) || (status_q == ST_SAT);
	assign clr_addr       = clr_q;
	assign out_valid      = out_valid_q;

endmodule
